### sv/ntc_pkg.sv
// package: widths, constants, register indexes and shared types of the zone monitor
package ntc_pkg;
	localparam int AVG_DEPTH    = 8;
	localparam int MEDIAN_DEPTH = 5;
	localparam int FULL_SCALE   = 4096;
	localparam int AVG_IW       = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
	localparam int MED_IW       = (MEDIAN_DEPTH > 1) ? $clog2(MEDIAN_DEPTH) : 1;
	localparam int FILL_W       = $clog2(AVG_DEPTH + 1);
	localparam int SUM_W        = 12 + $clog2(AVG_DEPTH + 1);
	localparam int NUM_W        = 12 + 20 + 4;
	localparam int DIV_CW       = $clog2(NUM_W + 1);

	localparam logic [3:0] REG_SERIES = 4'd0;
	localparam logic [3:0] REG_COLD   = 4'd1;
	localparam logic [3:0] REG_FREEZE = 4'd2;
	localparam logic [3:0] REG_COOL   = 4'd3;
	localparam logic [3:0] REG_WARM   = 4'd4;
	localparam logic [3:0] REG_HOT    = 4'd5;
	localparam logic [3:0] REG_CCOOL  = 4'd6;
	localparam logic [3:0] REG_CWARM  = 4'd7;

	localparam logic [2:0] ZONE_COLD    = 3'd0;
	localparam logic [2:0] ZONE_FREEZE  = 3'd1;
	localparam logic [2:0] ZONE_COOL    = 3'd2;
	localparam logic [2:0] ZONE_WARM    = 3'd3;
	localparam logic [2:0] ZONE_HOT     = 3'd4;
	localparam logic [2:0] ZONE_OVER    = 3'd5;
	localparam logic [2:0] ZONE_UNKNOWN = 3'd7;

	typedef struct packed {
		logic load;
		logic fill;
		logic med_step;
		logic avg_push;
		logic sum_step;
		logic div_start;
		logic div_step;
		logic finish;
	} ntc_cmd_t;

	typedef struct packed {
		logic fill_done;
		logic med_last;
		logic sum_last;
		logic div_last;
	} ntc_sts_t;
endpackage

### sv/ntc_if.sv
// valid/ready channel carrying one word of type data_t
interface ntc_if #(parameter type data_t = logic) ();
	logic  valid;
	logic  ready;
	data_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### sv/ntc_ctrl.sv
// controller: sequences the median, averaging, division and classification steps
module ntc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            out_full,
	output ntc_pkg::ntc_cmd_t cmd,
	input  ntc_pkg::ntc_sts_t sts
);
	import ntc_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MED  = 5'b00010,
		ST_SUM  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_WAIT = 5'b10000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (sts.fill_done) state_d = ST_MED;
					else cmd.fill = 1'b1;
				end
			end
			ST_MED: begin
				cmd.med_step = 1'b1;
				if (sts.med_last) state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum_step = 1'b1;
				if (sts.sum_last) state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = ST_WAIT;
			end
			ST_WAIT: begin
				// load the output register only on an edge where it is free
				if (!out_full) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		cmd.avg_push  = (state_q == ST_MED) && sts.med_last;
		cmd.div_start = (state_q == ST_SUM) && sts.sum_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end
endmodule

### sv/ntc_datapath.sv
// datapath: median window, average buffer, restoring divider and zone logic
module ntc_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  ntc_pkg::ntc_cmd_t cmd,
	output ntc_pkg::ntc_sts_t sts,
	input  logic [11:0]       sample,
	input  logic              charger_active,
	input  logic [19:0]       series_resistance,
	input  logic [31:0]       level_cold,
	input  logic [31:0]       level_freeze,
	input  logic [31:0]       level_cool,
	input  logic [31:0]       level_warm,
	input  logic [31:0]       level_hot,
	input  logic [4:0]        current_cool_code,
	input  logic [4:0]        current_warm_code,
	output logic [2:0]        zone,
	output logic              zone_changed,
	output logic [31:0]       resistance_x10,
	output logic [11:0]       average_sample,
	output logic              set_current,
	output logic [4:0]        current_code
);
	import ntc_pkg::*;

	logic [11:0]       win_q [MEDIAN_DEPTH];
	logic [11:0]       avg_q [AVG_DEPTH];
	logic [FILL_W-1:0] fill_q;
	logic [2:0]        last_zone_q;
	logic              charge_q;
	logic [MED_IW-1:0] mi_q;
	logic [MED_IW:0]   rank_q;
	logic [11:0]       med_q;
	logic              med_found_q;
	logic [AVG_IW-1:0] si_q;
	logic [SUM_W-1:0]  sum_q;
	logic [NUM_W-1:0]  num_q;
	logic [NUM_W-1:0]  rem_q;
	logic [12:0]       den_q;
	logic [DIV_CW-1:0] dc_q;
	logic              sat_q;
	logic [11:0]       mean_q;

	// rank of candidate mi: count smaller, and equal ones earlier in the window
	logic [MED_IW:0] below, equal_before;
	logic [11:0]     cand;
	always_comb begin
		cand = win_q[mi_q];
		below = '0;
		equal_before = '0;
		for (int k = 0; k < MEDIAN_DEPTH; k++) begin
			if (win_q[k] < cand) below = below + 1'b1;
			else if (win_q[k] == cand && k < int'(mi_q)) equal_before = equal_before + 1'b1;
		end
	end
	logic is_median;
	assign is_median = (below + equal_before) == (MED_IW+1)'(MEDIAN_DEPTH / 2);

	assign sts.fill_done = (fill_q == FILL_W'(AVG_DEPTH));
	assign sts.med_last  = (mi_q == MED_IW'(MEDIAN_DEPTH - 1));
	assign sts.sum_last  = (si_q == AVG_IW'(AVG_DEPTH - 1));
	assign sts.div_last  = (dc_q == DIV_CW'(NUM_W - 1));

	logic [SUM_W-1:0] sum_next;
	assign sum_next = sum_q + SUM_W'(avg_q[si_q]);
	logic [11:0] mean_next;
	assign mean_next = 12'(sum_next / AVG_DEPTH);
	logic [NUM_W:0] trial;
	assign trial = {rem_q, num_q[NUM_W-1]} - {{(NUM_W-12){1'b0}}, den_q};

	logic [11:0] med_sel;
	assign med_sel = (!med_found_q && is_median) ? cand : med_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			last_zone_q <= ZONE_UNKNOWN;
			for (int k = 0; k < MEDIAN_DEPTH; k++) win_q[k] <= '0;
		end else begin
			if (cmd.load) begin
				for (int k = 0; k < MEDIAN_DEPTH - 1; k++) win_q[k] <= win_q[k+1];
				win_q[MEDIAN_DEPTH-1] <= sample;
				if (cmd.fill) fill_q <= fill_q + 1'b1;
			end
			if (cmd.finish) last_zone_q <= zone;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			charge_q <= charger_active;
			mi_q <= '0;
			med_found_q <= 1'b0;
			if (cmd.fill) avg_q[fill_q[AVG_IW-1:0]] <= sample;
		end
		if (cmd.med_step) begin
			mi_q <= mi_q + 1'b1;
			med_q <= med_sel;
			if (is_median) med_found_q <= 1'b1;
			si_q <= '0;
			sum_q <= '0;
		end
		if (cmd.avg_push) begin
			for (int k = 0; k < AVG_DEPTH - 1; k++) avg_q[k] <= avg_q[k+1];
			avg_q[AVG_DEPTH-1] <= med_sel;
		end
		if (cmd.sum_step) begin
			si_q <= si_q + 1'b1;
			sum_q <= sum_next;
		end
		if (cmd.div_start) begin
			mean_q <= mean_next;
			sat_q <= ({1'b0, mean_next} >= 13'(FULL_SCALE));
			den_q <= 13'(FULL_SCALE) - {1'b0, mean_next};
			num_q <= NUM_W'(mean_next) * NUM_W'(series_resistance) * NUM_W'(10);
			rem_q <= '0;
			dc_q <= '0;
		end
		if (cmd.div_step) begin
			dc_q <= dc_q + 1'b1;
			if (!trial[NUM_W]) begin
				rem_q <= trial[NUM_W-1:0];
				num_q <= {num_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[NUM_W-2:0], num_q[NUM_W-1]};
				num_q <= {num_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	// quotient ends up in num_q after the last step
	always_comb begin
		if (sat_q || (num_q[NUM_W-1:32] != '0)) resistance_x10 = '1;
		else resistance_x10 = num_q[31:0];
		if (resistance_x10 >= level_cold) zone = ZONE_COLD;
		else if (resistance_x10 > level_freeze) zone = ZONE_FREEZE;
		else if (resistance_x10 > level_cool) zone = ZONE_COOL;
		else if (resistance_x10 > level_warm) zone = ZONE_WARM;
		else if (resistance_x10 > level_hot) zone = ZONE_HOT;
		else zone = ZONE_OVER;
		zone_changed = (zone != last_zone_q);
		average_sample = mean_q;
		set_current = 1'b0;
		current_code = '0;
		if (zone_changed && charge_q && zone == ZONE_COOL) begin
			set_current = 1'b1;
			current_code = current_cool_code;
		end else if (zone_changed && charge_q && zone == ZONE_WARM) begin
			set_current = 1'b1;
			current_code = current_warm_code;
		end
	end
endmodule

### sv/ntc_temperature_zone_monitor_core.sv
// top level: thermistor zone monitor with config registers and output register
//
// channel   role    word
// in_ch     sink    sample, charger_active
// out_ch    source  zone, zone_changed, resistance_x10, average_sample, set_current,
//                   current_code
// cfg       write   cfg_we, cfg_index, cfg_data
//
// fill-phase words give no result
// later words pass through the per-entry median rank scan, the serial sum and the
// 36-step restoring divider
// a result sits in the output register, the next word is taken while it waits
// arst_n clears the window, fill count, last zone and registers to their defaults
module ntc_temperature_zone_monitor_core (
	input  logic        clk,
	input  logic        arst_n,
	ntc_if.sink         in_ch,
	ntc_if.source       out_ch,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import ntc_pkg::*;

	logic [19:0] series_q;
	logic [31:0] cold_q, freeze_q, cool_q, warm_q, hot_q;
	logic [4:0]  ccool_q, cwarm_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			series_q <= 20'd100000;
			cold_q   <= 32'd923800;
			freeze_q <= 32'd543014;
			cool_q   <= 32'd262000;
			warm_q   <= 32'd56455;
			hot_q    <= 32'd30240;
			ccool_q  <= 5'd2;
			cwarm_q  <= 5'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SERIES: series_q <= cfg_data[19:0];
				REG_COLD:   cold_q   <= cfg_data;
				REG_FREEZE: freeze_q <= cfg_data;
				REG_COOL:   cool_q   <= cfg_data;
				REG_WARM:   warm_q   <= cfg_data;
				REG_HOT:    hot_q    <= cfg_data;
				REG_CCOOL:  ccool_q  <= cfg_data[4:0];
				REG_CWARM:  cwarm_q  <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	ntc_cmd_t cmd;
	ntc_sts_t sts;
	logic     out_valid_q;
	logic [2:0]  zone;
	logic        zone_changed, set_current;
	logic [31:0] resistance_x10;
	logic [11:0] average_sample;
	logic [4:0]  current_code;

	ntc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.out_full (out_valid_q && !out_ch.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	ntc_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.sample            (in_ch.data.sample),
		.charger_active    (in_ch.data.charger_active),
		.series_resistance (series_q),
		.level_cold        (cold_q),
		.level_freeze      (freeze_q),
		.level_cool        (cool_q),
		.level_warm        (warm_q),
		.level_hot         (hot_q),
		.current_cool_code (ccool_q),
		.current_warm_code (cwarm_q),
		.zone              (zone),
		.zone_changed      (zone_changed),
		.resistance_x10    (resistance_x10),
		.average_sample    (average_sample),
		.set_current       (set_current),
		.current_code      (current_code)
	);

	// output register, loaded only when empty or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.finish) out_valid_q <= 1'b1;
		else if (out_ch.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_ch.data.zone           <= zone;
			out_ch.data.zone_changed   <= zone_changed;
			out_ch.data.resistance_x10 <= resistance_x10;
			out_ch.data.average_sample <= average_sample;
			out_ch.data.set_current    <= set_current;
			out_ch.data.current_code   <= current_code;
		end
	end

	assign out_ch.valid = out_valid_q;
endmodule
